// ----- src/sm3_pkg.sv -----
// SM3 package: types, constants and round helper functions.
// Used by every module of the SM3 hash core.
package sm3_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_EMIT
    } state_t;

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [31:0] PAD_WORD = 32'h80000000;

    localparam logic [31:0] SM3_IV [8] = '{
        32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
    };

    localparam logic CFG_RESUME = 1'b0;
    localparam logic CFG_OFFSET = 1'b1;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            rotl = d[63:32];
        end
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
    endfunction

    // Round control handed from the sequencer to the round unit
    typedef struct packed {
        logic       load;
        logic       step;
        logic       fold;
        logic [5:0] rnd;
    } rnd_ctl_t;

endpackage

// ----- src/sm3_round.sv -----
// SM3 round unit: working registers A..H, one round per step, and the
// final fold into the chaining value. Depends on sm3_pkg.
module sm3_round (
    input  logic             clk,
    input  sm3_pkg::rnd_ctl_t ctl,
    input  logic [31:0]      wj,
    input  logic [31:0]      wj4,
    input  logic [31:0]      chain_in [8],
    output logic [31:0]      fold_out [8]
);
    import sm3_pkg::*;

    logic [31:0] v_reg [8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, t;
    logic        hi;

    // Evaluate one compression round and the fold output
    always_comb
    begin
        hi  = (ctl.rnd > 6'd15);
        t   = hi ? T_HIGH : T_LOW;
        a12 = rotl(v_reg[0], 5'd12);
        ss1 = rotl(a12 + v_reg[4] + rotl(t, ctl.rnd[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (!hi)
        begin
            ff = v_reg[0] ^ v_reg[1] ^ v_reg[2];
            gg = v_reg[4] ^ v_reg[5] ^ v_reg[6];
        end
        else
        begin
            ff = (v_reg[0] & v_reg[1]) | (v_reg[0] & v_reg[2]) | (v_reg[1] & v_reg[2]);
            gg = (v_reg[4] & v_reg[5]) | (~v_reg[4] & v_reg[6]);
        end
        tt1 = ff + v_reg[3] + ss2 + (wj ^ wj4);
        tt2 = gg + v_reg[7] + ss1 + wj;
        for (int i = 0; i < 8; i++)
            fold_out[i] = chain_in[i] ^ v_reg[i];
    end

    // Load, advance or hold the working registers
    always_ff @(posedge clk)
    begin
        if (ctl.load)
            v_reg <= chain_in;
        else if (ctl.step)
        begin
            v_reg[3] <= v_reg[2];
            v_reg[2] <= rotl(v_reg[1], 5'd9);
            v_reg[1] <= v_reg[0];
            v_reg[0] <= tt1;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= rotl(v_reg[5], 5'd19);
            v_reg[5] <= v_reg[4];
            v_reg[4] <= perm0(tt2);
        end
    end

endmodule

// ----- src/sm3_hash_with_resume_core.sv -----
// SM3 hash core with resume mode: top level with word gathering, padding,
// message expansion window and sequencer. Depends on sm3_pkg, sm3_round.
//
// One item (message word) is taken per cycle while a block fills; the
// sixteenth word of a block starts a compression (a load, 64 rounds
// at one round per cycle in the shared round unit, expanding the message
// schedule in a 16-word sliding window, and a fold),
// during which no item is accepted. A final word then costs the padding
// words and up to two compressions, plus the delivery of digest words
// A..H, each held until taken.
module sm3_hash_with_resume_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] word,
    input  logic [2:0]  valid_bytes,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] digest_word,
    output logic        last_res
);
    import sm3_pkg::*;

    state_t      state_reg, state_next;
    logic [31:0] win_reg [16];
    logic [31:0] chain_reg [8];
    logic [31:0] fold_out [8];
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] bits_reg, bits_next;
    logic        active_reg, active_next;
    logic        resume_reg;
    logic [31:0] offset_reg;
    logic [5:0]  rnd_reg, rnd_next;
    logic        padding_reg, padding_next;
    logic        lenb_reg, lenb_next;
    logic        lenh_reg, lenh_next;
    logic        mark_reg, mark_next;
    logic [2:0]  emit_reg, emit_next;
    logic [63:0] len_reg, len_next;
    rnd_ctl_t    ctl;
    logic        accept;
    logic [2:0]  nb;
    logic [31:0] mword, pad_w, wnew, push_w;
    logic        push, need_two;
    logic [31:0] wj4;

    sm3_round u_round (
        .clk      (clk),
        .ctl      (ctl),
        .wj       (win_reg[0]),
        .wj4      (wj4),
        .chain_in (chain_reg),
        .fold_out (fold_out)
    );

    assign accept = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign digest_word = chain_reg[emit_reg];
    assign last_res = (emit_reg == 3'd7);

    // Mask the item and form the padded word
    always_comb
    begin
        nb = (!last || valid_bytes > 3'd4) ? 3'd4 : valid_bytes;
        case (nb)
            3'd0: mword = 32'h0;
            3'd1: mword = word & 32'hFF000000;
            3'd2: mword = word & 32'hFFFF0000;
            3'd3: mword = word & 32'hFFFFFF00;
            default: mword = word;
        endcase
        case (nb)
            3'd0: pad_w = 32'h80000000;
            3'd1: pad_w = mword | 32'h00800000;
            3'd2: pad_w = mword | 32'h00008000;
            3'd3: pad_w = mword | 32'h00000080;
            default: pad_w = mword;
        endcase
        // Next schedule word: W[j+16] from the window
        wnew = perm1(win_reg[0] ^ win_reg[7] ^ rotl(win_reg[13], 5'd15))
             ^ rotl(win_reg[3], 5'd7) ^ win_reg[10];
        // W[j+4], always taken from position 4 of the window
        wj4 = win_reg[4];
    end

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        bits_next    = bits_reg;
        active_next  = active_reg;
        rnd_next     = rnd_reg;
        padding_next = padding_reg;
        lenb_next    = lenb_reg;
        lenh_next    = lenh_reg;
        mark_next    = mark_reg;
        emit_next    = emit_reg;
        len_next     = len_reg;
        ctl          = '{load: 1'b0, step: 1'b0, fold: 1'b0, rnd: rnd_reg};
        push         = 1'b0;
        push_w       = 32'h0;
        need_two     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    bits_next = (active_reg ? bits_reg : 64'd0) + {58'd0, nb, 3'd0};
                    active_next = 1'b1;
                    if (!active_reg)
                        pos_next = 4'd0;
                    push = 1'b1;
                    if (!last)
                    begin
                        push_w = mword;
                        pos_next = (active_reg ? pos_reg : 4'd0) + 4'd1;
                        if ((active_reg ? pos_reg : 4'd0) == 4'd15)
                        begin
                            state_next = ST_EXPAND;
                            padding_next = 1'b0;
                        end
                    end
                    else
                    begin
                        len_next = bits_next + {23'd0, offset_reg, 9'd0};
                        padding_next = 1'b1;
                        lenb_next = 1'b0;
                        lenh_next = 1'b0;
                        // Full final word needs the pad marker as a second word
                        push_w = (nb == 3'd4) ? mword : pad_w;
                        pos_next = (active_reg ? pos_reg : 4'd0) + 4'd1;
                        need_two = (nb == 3'd4);
                        mark_next = need_two;
                        // Compress a block filled by the final word first
                        state_next = ((active_reg ? pos_reg : 4'd0) == 4'd15)
                                   ? ST_EXPAND : ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                // Marker word still owed after a full final word
                push = 1'b1;
                if (mark_reg)
                begin
                    push_w = PAD_WORD;
                    mark_next = 1'b0;
                end
                else if (pos_reg == 4'd14)
                begin
                    push_w = len_reg[63:32];
                    lenh_next = 1'b1;
                end
                else if (lenh_reg && pos_reg == 4'd15)
                begin
                    push_w = len_reg[31:0];
                    lenb_next = 1'b1;
                end
                else
                    push_w = 32'h0;
                pos_next = pos_reg + 4'd1;
                if (pos_reg == 4'd15)
                    state_next = ST_EXPAND;
            end
            ST_EXPAND:
            begin
                ctl.load = 1'b1;
                rnd_next = 6'd0;
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                ctl.step = 1'b1;
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                    state_next = ST_FOLD;
            end
            ST_FOLD:
            begin
                ctl.fold = 1'b1;
                rnd_next = 6'd0;
                if (!padding_reg)
                    state_next = ST_IDLE;
                else if (lenb_reg)
                begin
                    state_next = ST_EMIT;
                    emit_next = 3'd0;
                end
                else
                    state_next = ST_PAD;
            end
            ST_EMIT:
            begin
                if (!out_stall)
                begin
                    emit_next = emit_reg + 3'd1;
                    if (emit_reg == 3'd7)
                    begin
                        state_next = ST_IDLE;
                        active_next = 1'b0;
                        padding_next = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            pos_reg     <= 4'd0;
            bits_reg    <= 64'd0;
            active_reg  <= 1'b0;
            rnd_reg     <= 6'd0;
            padding_reg <= 1'b0;
            lenb_reg    <= 1'b0;
            lenh_reg    <= 1'b0;
            mark_reg    <= 1'b0;
            emit_reg    <= 3'd0;
            resume_reg  <= 1'b0;
            offset_reg  <= 32'd0;
            chain_reg   <= SM3_IV;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            bits_reg    <= bits_next;
            active_reg  <= active_next;
            rnd_reg     <= rnd_next;
            padding_reg <= padding_next;
            lenb_reg    <= lenb_next;
            lenh_reg    <= lenh_next;
            mark_reg    <= mark_next;
            emit_reg    <= emit_next;
            if (cfg_we && cfg_index == CFG_RESUME)
                resume_reg <= cfg_data[0];
            if (cfg_we && cfg_index == CFG_OFFSET)
                offset_reg <= cfg_data;
            // Start of message: load IV unless resuming
            if (accept && !active_reg && !resume_reg)
                chain_reg <= SM3_IV;
            else if (ctl.fold)
                chain_reg <= fold_out;
        end
    end

    // Payload: length and block window (shifts during rounds)
    always_ff @(posedge clk)
    begin
        len_reg <= len_next;
        if (push)
            win_reg[pos_reg & {4{active_reg | (state_reg != ST_IDLE)}}] <= push_w;
        else if (ctl.step)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= wnew;
        end
    end

    // Digest is only shown while items are stalled, a fold follows round 63, and the digest run ends after word H
    a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_stall == 1'b0)
        else $error("digest shown while accepting items");
    a_fold_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FOLD) |-> $past(state_reg == ST_ROUND && rnd_reg == 6'd63))
        else $error("fold without full round sequence");
    a_last_eighth: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last_res && !out_stall) |=> (state_reg == ST_IDLE))
        else $error("digest run did not end after eighth word");

endmodule
